@@ rtl/zobrist_position_hasher_defines.svh @@
// Assertion macros shared by the Zobrist position hasher modules.
`ifndef ZOBRIST_POSITION_HASHER_DEFINES_SVH
`define ZOBRIST_POSITION_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
`define ZPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);
`define ZPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ZPH_ASSERT_IMP(lbl, ante, cons, msg)
`define ZPH_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/zph_pkg.sv @@
// Shared types, codes and the key generator step for the Zobrist position hasher.
package zph_pkg;

  localparam int HASH_W      = 64;
  localparam int BB_W        = 25;
  localparam int SQ_W        = 5;
  localparam int MAX_SQUARES = 32;

  localparam logic [HASH_W-1:0] SEED_RESET = 64'd1;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [BB_W-1:0]   bitboard_t;
  typedef logic [SQ_W-1:0]   square_t;

  typedef enum logic [1:0] {
    OP_FULL = 2'd0,
    OP_PAWN = 2'd1,
    OP_MOVE = 2'd2,
    OP_SIDE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_WHITE = 2'd0,
    KIND_BLACK = 2'd1,
    KIND_LONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    KG_KEYS  = 2'd0,
    KG_SIDE  = 2'd1,
    KG_READY = 2'd2
  } kg_state_t;

  // One xorshift64 step with shifts 13, 7 and 17.
  function automatic hash_t xorshift64(input hash_t v);
    hash_t t;
    t = v ^ (v << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

endpackage

@@ rtl/zph_keygen.sv @@
// Key table generator: xorshift64 sequencer and the key registers it fills.
`include "zobrist_position_hasher_defines.svh"
module zph_keygen #(
  parameter int SQUARES = 25
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_valid,
  input  zph_pkg::hash_t                            cfg_seed,
  output logic                                      busy,
  output logic [SQUARES-1:0][zph_pkg::HASH_W-1:0]   white_keys,
  output logic [SQUARES-1:0][zph_pkg::HASH_W-1:0]   black_keys,
  output logic [SQUARES-1:0][zph_pkg::HASH_W-1:0]   lone_keys,
  output zph_pkg::hash_t                            side_key
);
  import zph_pkg::*;

  localparam int SQW = (SQUARES > 1) ? $clog2(SQUARES) : 1;

  kg_state_t       state_r, state_nxt;
  hash_t           gen_r, gen_nxt;
  logic [SQW-1:0]  sq_r, sq_nxt;
  kind_t           kind_r, kind_nxt;
  hash_t           key_nxt;

  logic [SQUARES-1:0][HASH_W-1:0] white_r;
  logic [SQUARES-1:0][HASH_W-1:0] black_r;
  logic [SQUARES-1:0][HASH_W-1:0] lone_r;
  hash_t                          side_r;

  assign key_nxt = xorshift64(gen_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KG_KEYS;
      gen_r   <= SEED_RESET;
      sq_r    <= '0;
      kind_r  <= KIND_WHITE;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      sq_r    <= sq_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    gen_nxt   = gen_r;
    sq_nxt    = sq_r;
    kind_nxt  = kind_r;
    if (cfg_valid) begin
      // A seed write restarts the whole table build.
      state_nxt = KG_KEYS;
      gen_nxt   = cfg_seed;
      sq_nxt    = '0;
      kind_nxt  = KIND_WHITE;
    end else begin
      unique case (state_r)
        KG_KEYS: begin
          gen_nxt = key_nxt;
          case (kind_r)
            KIND_WHITE: kind_nxt = KIND_BLACK;
            KIND_BLACK: kind_nxt = KIND_LONE;
            default: begin
              kind_nxt = KIND_WHITE;
              if (sq_r == SQW'(SQUARES - 1)) begin
                state_nxt = KG_SIDE;
              end else begin
                sq_nxt = sq_r + 1'b1;
              end
            end
          endcase
        end
        KG_SIDE: begin
          gen_nxt   = key_nxt;
          state_nxt = KG_READY;
        end
        KG_READY: state_nxt = KG_READY;
        default:  state_nxt = KG_READY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!cfg_valid && state_r == KG_KEYS) begin
      case (kind_r)
        KIND_WHITE: white_r[sq_r] <= key_nxt;
        KIND_BLACK: black_r[sq_r] <= key_nxt;
        default:    lone_r[sq_r]  <= key_nxt;
      endcase
    end
    if (!cfg_valid && state_r == KG_SIDE) begin
      side_r <= key_nxt;
    end
  end

  assign busy       = (state_r != KG_READY);
  assign white_keys = white_r;
  assign black_keys = black_r;
  assign lone_keys  = lone_r;
  assign side_key   = side_r;

  `ZPH_ASSERT_NXT(a_ready_holds, state_r == KG_READY && !cfg_valid, state_r == KG_READY,
    "key table left ready without a seed write")
  `ZPH_ASSERT_NXT(a_side_last, state_r == KG_SIDE && !cfg_valid, state_r == KG_READY,
    "side key step not followed by ready")

endmodule

@@ rtl/zph_hash_pipe.sv @@
// Three-stage hash datapath: operation decode, masked XOR of key lanes, final fold.
`include "zobrist_position_hasher_defines.svh"
module zph_hash_pipe #(
  parameter int SQUARES = 25
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  zph_pkg::op_t                              op,
  input  zph_pkg::bitboard_t                        white_bits,
  input  zph_pkg::bitboard_t                        black_bits,
  input  zph_pkg::square_t                          lone_sq,
  input  logic                                      side_move,
  input  zph_pkg::hash_t                            hash_in,
  input  zph_pkg::square_t                          pawn_sq,
  input  logic                                      pawn_white,
  input  zph_pkg::square_t                          from_sq,
  input  zph_pkg::square_t                          to_sq,
  input  logic [SQUARES-1:0][zph_pkg::HASH_W-1:0]   white_keys,
  input  logic [SQUARES-1:0][zph_pkg::HASH_W-1:0]   black_keys,
  input  logic [SQUARES-1:0][zph_pkg::HASH_W-1:0]   lone_keys,
  input  zph_pkg::hash_t                            side_key,
  output logic                                      out_valid,
  output zph_pkg::hash_t                            out_hash
);
  import zph_pkg::*;

  localparam int GRP  = 8;
  localparam int NGRP = (SQUARES + GRP - 1) / GRP;

  // One-hot lane mask of a square; squares off the board select nothing.
  function automatic logic [SQUARES-1:0] sq_onehot(input square_t sq);
    logic [SQUARES-1:0] m;
    for (int i = 0; i < SQUARES; i++) begin
      m[i] = (sq == SQ_W'(i));
    end
    return m;
  endfunction

  // Bitboard as a lane mask; bits at or above the board size are dropped.
  function automatic logic [SQUARES-1:0] bb_mask(input bitboard_t bb);
    logic [MAX_SQUARES-1:0] wide;
    logic [SQUARES-1:0]     m;
    wide = MAX_SQUARES'(bb);
    for (int i = 0; i < SQUARES; i++) begin
      m[i] = wide[i];
    end
    return m;
  endfunction

  // Stage 1: lane masks.
  logic               s1_valid_r;
  logic [SQUARES-1:0] s1_wmask_r, s1_bmask_r, s1_lmask_r;
  logic               s1_side_r;
  hash_t              s1_base_r;

  logic [SQUARES-1:0] wmask_nxt, bmask_nxt, lmask_nxt;
  logic               side_nxt;
  hash_t              base_nxt;

  always_comb begin
    wmask_nxt = '0;
    bmask_nxt = '0;
    lmask_nxt = '0;
    side_nxt  = 1'b0;
    base_nxt  = hash_in;
    unique case (op)
      OP_FULL: begin
        wmask_nxt = bb_mask(white_bits);
        bmask_nxt = bb_mask(black_bits);
        lmask_nxt = sq_onehot(lone_sq);
        side_nxt  = side_move;
        base_nxt  = '0;
      end
      OP_PAWN: begin
        if (pawn_white) begin
          wmask_nxt = sq_onehot(pawn_sq);
        end else begin
          bmask_nxt = sq_onehot(pawn_sq);
        end
      end
      // Equal squares cancel in the XOR, leaving the hash unchanged.
      OP_MOVE: lmask_nxt = sq_onehot(from_sq) ^ sq_onehot(to_sq);
      OP_SIDE: side_nxt  = 1'b1;
      default: side_nxt  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_wmask_r <= wmask_nxt;
    s1_bmask_r <= bmask_nxt;
    s1_lmask_r <= lmask_nxt;
    s1_side_r  <= side_nxt;
    s1_base_r  <= base_nxt;
  end

  // Stage 2: partial XOR over groups of eight squares.
  logic                        s2_valid_r;
  logic [NGRP-1:0][HASH_W-1:0] s2_part_r, part_nxt;
  hash_t                       s2_base_r;

  always_comb begin
    int idx;
    part_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      for (int j = 0; j < GRP; j++) begin
        idx = g * GRP + j;
        if (idx < SQUARES) begin
          part_nxt[g] = part_nxt[g]
                      ^ (white_keys[idx] & {HASH_W{s1_wmask_r[idx]}})
                      ^ (black_keys[idx] & {HASH_W{s1_bmask_r[idx]}})
                      ^ (lone_keys[idx]  & {HASH_W{s1_lmask_r[idx]}});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_part_r <= part_nxt;
    s2_base_r <= s1_base_r ^ (side_key & {HASH_W{s1_side_r}});
  end

  // Stage 3: fold the group partials into the result.
  logic  out_valid_r;
  hash_t out_hash_r, fold_nxt;

  always_comb begin
    fold_nxt = s2_base_r;
    for (int g = 0; g < NGRP; g++) begin
      fold_nxt = fold_nxt ^ s2_part_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hash_r <= fold_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

  `ZPH_ASSERT_IMP(a_beat_emerges, in_valid, ##3 out_valid_r,
    "accepted beat did not produce a result three cycles later")
  `ZPH_ASSERT_IMP(a_no_phantom, !in_valid, ##3 !out_valid_r,
    "result strobe without an accepted beat")

endmodule

@@ rtl/zobrist_position_hasher.sv @@
// Top level of the Zobrist position hasher: key table generator and hash pipeline.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  -------------------------------------------
//   input    start / busy           in_operation .. in_to_square (ten fields)
//   result   out_valid (strobe)     out_hash_out
//   config   cfg_valid / cfg_ready  cfg_seed
//
// A beat is taken at every clock edge with start high and busy low, so one
// position can be hashed per cycle while busy is low; each result shows on
// out_hash_out with out_valid high once its beat has passed the three register
// stages: operation decode into lane masks, masked XOR over groups of eight
// squares, and the final fold.
// After reset, and after every seed write, busy stays high while the xorshift64
// generator fills the key table one key per cycle, the side key last.
// The result side has no back-pressure; cfg_ready is always high. A seed is to
// be written only while no beat is in flight; the block does not enforce this.
module zobrist_position_hasher #(
  parameter int SQUARES = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  zph_pkg::op_t       in_operation,
  input  zph_pkg::bitboard_t in_white_pawn_bits,
  input  zph_pkg::bitboard_t in_black_pawn_bits,
  input  zph_pkg::square_t   in_lone_piece_square,
  input  logic               in_white_moves_next,
  input  zph_pkg::hash_t     in_hash_in,
  input  zph_pkg::square_t   in_pawn_square,
  input  logic               in_pawn_is_white,
  input  zph_pkg::square_t   in_from_square,
  input  zph_pkg::square_t   in_to_square,
  output logic               out_valid,
  output zph_pkg::hash_t     out_hash_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  zph_pkg::hash_t     cfg_seed
);
  import zph_pkg::*;

  logic                           table_busy;
  logic                           in_valid;
  logic [SQUARES-1:0][HASH_W-1:0] white_keys;
  logic [SQUARES-1:0][HASH_W-1:0] black_keys;
  logic [SQUARES-1:0][HASH_W-1:0] lone_keys;
  hash_t                          side_key;

  // Seed writes are always taken; they restart the table build.
  assign cfg_ready = 1'b1;
  assign busy      = table_busy;
  assign in_valid  = start && !table_busy;

  zph_keygen #(
    .SQUARES (SQUARES)
  ) u_keygen (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_seed   (cfg_seed),
    .busy       (table_busy),
    .white_keys (white_keys),
    .black_keys (black_keys),
    .lone_keys  (lone_keys),
    .side_key   (side_key)
  );

  zph_hash_pipe #(
    .SQUARES (SQUARES)
  ) u_hash_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .op         (in_operation),
    .white_bits (in_white_pawn_bits),
    .black_bits (in_black_pawn_bits),
    .lone_sq    (in_lone_piece_square),
    .side_move  (in_white_moves_next),
    .hash_in    (in_hash_in),
    .pawn_sq    (in_pawn_square),
    .pawn_white (in_pawn_is_white),
    .from_sq    (in_from_square),
    .to_sq      (in_to_square),
    .white_keys (white_keys),
    .black_keys (black_keys),
    .lone_keys  (lone_keys),
    .side_key   (side_key),
    .out_valid  (out_valid),
    .out_hash   (out_hash_out)
  );

endmodule
